// File: design/fnlr_pkg.sv
package fnlr_pkg;

  localparam int CODE_W        = 10;
  localparam int TYPE_W        = 5;
  localparam int VALUE_W       = 2;
  localparam int TABLE_ENTRIES = 19;
  localparam int TBL_IDX_W     = 5;

  localparam logic [TYPE_W-1:0]  EV_KEY     = 5'd1;
  localparam logic [VALUE_W-1:0] KEY_RELEASE = 2'd0;
  localparam logic [VALUE_W-1:0] KEY_REPEAT  = 2'd2;
  localparam logic [CODE_W-1:0]  FN_CODE_RESET = 10'd58;

  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  ev_type;
    code_t              key_code;
    logic [VALUE_W-1:0] key_value;
  } item_t;

  // Request from the sequencer to the output stage
  typedef struct packed {
    logic               req;
    code_t              code;
    logic [VALUE_W-1:0] value;
    logic               last;
  } emit_t;

  // Answer of the shared compare unit for the entry under test
  typedef struct packed {
    logic  hit;
    code_t base;
    code_t remap;
  } cmp_rsp_t;

  function automatic code_t base_code(input logic [TBL_IDX_W-1:0] idx);
    code_t c;
    case (idx)
      5'd0:  c = 10'd14;
      5'd1:  c = 10'd28;
      5'd2:  c = 10'd59;
      5'd3:  c = 10'd60;
      5'd4:  c = 10'd61;
      5'd5:  c = 10'd62;
      5'd6:  c = 10'd63;
      5'd7:  c = 10'd64;
      5'd8:  c = 10'd65;
      5'd9:  c = 10'd66;
      5'd10: c = 10'd67;
      5'd11: c = 10'd68;
      5'd12: c = 10'd87;
      5'd13: c = 10'd88;
      5'd14: c = 10'd103;
      5'd15: c = 10'd108;
      5'd16: c = 10'd105;
      5'd17: c = 10'd106;
      5'd18: c = 10'd1;
      default: c = 10'd0;
    endcase
    return c;
  endfunction

  function automatic code_t remap_code(input logic [TBL_IDX_W-1:0] idx);
    code_t c;
    case (idx)
      5'd0:  c = 10'd111;
      5'd1:  c = 10'd110;
      5'd2:  c = 10'd224;
      5'd3:  c = 10'd225;
      5'd4:  c = 10'd120;
      5'd5:  c = 10'd204;
      5'd6:  c = 10'd229;
      5'd7:  c = 10'd230;
      5'd8:  c = 10'd165;
      5'd9:  c = 10'd164;
      5'd10: c = 10'd163;
      5'd11: c = 10'd113;
      5'd12: c = 10'd114;
      5'd13: c = 10'd115;
      5'd14: c = 10'd104;
      5'd15: c = 10'd109;
      5'd16: c = 10'd102;
      5'd17: c = 10'd107;
      5'd18: c = 10'd58;
      default: c = 10'd0;
    endcase
    return c;
  endfunction

endpackage

// File: design/fnlr_in_if.sv
interface fnlr_in_if import fnlr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  ev_type;
  logic [CODE_W-1:0]  key_code;
  logic [VALUE_W-1:0] key_value;

  modport source (output valid, output ev_type, output key_code, output key_value,
                  input ready);
  modport sink   (input valid, input ev_type, input key_code, input key_value,
                  output ready);
endinterface

// File: design/fnlr_out_if.sv
interface fnlr_out_if import fnlr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  out_code;
  logic [VALUE_W-1:0] out_value;
  logic               last;

  modport source (output valid, output out_code, output out_value, output last,
                  input ready);
  modport sink   (input valid, input out_code, input out_value, input last,
                  output ready);
endinterface

// File: design/fnlr_cmp.sv
module fnlr_cmp import fnlr_pkg::*; #(
  parameter int IDX_W = 5
) (
  input  logic [IDX_W-1:0] idx,
  input  code_t            code,
  output cmp_rsp_t         rsp
);

  logic [TBL_IDX_W-1:0] tidx;

  // Look up one table entry and test it against the latched code
  always_comb begin
    tidx      = TBL_IDX_W'(idx);
    rsp.base  = base_code(tidx);
    rsp.remap = remap_code(tidx);
    rsp.hit   = (rsp.base == code);
  end

endmodule

// File: design/fnlr_seq.sv
module fnlr_seq import fnlr_pkg::*; #(
  parameter int ACTIVE     = 19,
  parameter int IDX_W      = 5,
  parameter int CODE_SPACE = 768
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  code_t            cfg_wr_data,
  input  logic             in_acc,
  input  item_t            item,
  output logic             in_ready,
  output logic [IDX_W-1:0] idx,
  output code_t            cur_code,
  input  cmp_rsp_t         rsp,
  input  logic             out_free,
  output emit_t            emit
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_SEARCH = 5'b00100,
    S_FNSCAN = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t             state, state_next;
  logic [IDX_W-1:0]   idx_next;
  code_t              cur_code_next;
  logic [TYPE_W-1:0]  cur_type;
  logic [VALUE_W-1:0] cur_value;
  code_t              fn_key;
  logic               fn_held, fn_held_next;
  logic [ACTIVE-1:0]  held, held_next;
  logic [ACTIVE-1:0]  supp, supp_next;
  logic [ACTIVE-1:0]  held_clr;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    cur_code_next = cur_code;
    fn_held_next  = fn_held;
    held_next     = held;
    supp_next     = supp;
    held_clr      = held;
    held_clr[idx] = 1'b0;
    emit          = '0;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          cur_code_next = item.key_code;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        idx_next = '0;
        if (cur_type != EV_KEY) begin
          state_next = S_IDLE;
        end else if (cur_code == fn_key) begin
          if (cur_value == KEY_REPEAT) begin
            state_next = S_IDLE;
          end else begin
            fn_held_next = (cur_value != KEY_RELEASE);
            state_next   = S_FNSCAN;
          end
        end else if ({1'b0, cur_code} >= (CODE_W+1)'(CODE_SPACE)) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (rsp.hit) begin
          if (cur_value == KEY_RELEASE) begin
            held_next[idx] = 1'b0;
            supp_next[idx] = 1'b0;
            cur_code_next  = fn_held ? rsp.remap : cur_code;
            state_next     = S_EMIT;
          end else if (supp[idx]) begin
            // drop press or repeat of a suppressed key
            state_next = S_IDLE;
          end else begin
            held_next[idx] = 1'b1;
            cur_code_next  = fn_held ? rsp.remap : cur_code;
            state_next     = S_EMIT;
          end
        end else if (idx == IDX_W'(ACTIVE - 1)) begin
          state_next = S_EMIT;
        end else begin
          idx_next = IDX_W'(idx + 1'b1);
        end
      end
      S_FNSCAN: begin
        if (held == '0) begin
          state_next = S_IDLE;
        end else if (held[idx]) begin
          emit.req   = 1'b1;
          emit.code  = fn_held ? rsp.base : rsp.remap;
          emit.value = KEY_RELEASE;
          emit.last  = (held_clr == '0);
          if (out_free) begin
            held_next[idx] = 1'b0;
            supp_next[idx] = 1'b1;
            idx_next       = IDX_W'(idx + 1'b1);
          end
        end else begin
          idx_next = IDX_W'(idx + 1'b1);
        end
      end
      S_EMIT: begin
        emit.req   = 1'b1;
        emit.code  = cur_code;
        emit.value = cur_value;
        emit.last  = 1'b1;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fn_held <= 1'b0;
      held    <= '0;
      supp    <= '0;
      fn_key  <= FN_CODE_RESET;
    end else begin
      state   <= state_next;
      fn_held <= fn_held_next;
      held    <= held_next;
      supp    <= supp_next;
      if (cfg_wr_en) begin
        fn_key <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    cur_code <= cur_code_next;
    if (in_acc) begin
      cur_type  <= item.ev_type;
      cur_value <= item.key_value;
    end
  end

endmodule

// File: design/fnlr_out_reg.sv
module fnlr_out_reg import fnlr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  emit_t       emit,
  output logic        out_free,
  fnlr_out_if.source  key_out
);

  logic valid;

  assign out_free      = !valid || key_out.ready;
  assign key_out.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_free) begin
      valid <= emit.req;
    end
  end

  // Payload holds while the sink stalls
  always_ff @(posedge clk) begin
    if (out_free && emit.req) begin
      key_out.out_code  <= emit.code;
      key_out.out_value <= emit.value;
      key_out.last      <= emit.last;
    end
  end

endmodule

// File: design/fn_layer_key_remapper_top.sv
// Channel   Dir  Payload                            Handshake
// key_in    in   ev_type, key_code, key_value       valid/ready, one event per request
// key_out   out  out_code, out_value, last          valid/ready, one key event per request
// cfg       in   cfg_wr_data (Fn key code)          cfg_wr_en, no back-pressure
//
// key_in.ready is high only while the sequencer is idle. A non-key event or Fn repeat is
// dropped after decode. Another key is decoded, its table entries are compared one per cycle
// in the shared unit, and the result is emitted (a suppressed press or repeat is dropped).
// A Fn event is decoded, then the held entries are scanned. Back-pressure on key_out stalls the scan or
// the final emit; the output register frees the sequencer while the last result waits.
// rst is synchronous: Fn flag, marks and the Fn key code (58) reset at once.
module fn_layer_key_remapper_top import fnlr_pkg::*; #(
  parameter int NUM_MAPPED = 19,
  parameter int CODE_SPACE = 768
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  code_t      cfg_wr_data,
  fnlr_in_if.sink    key_in,
  fnlr_out_if.source key_out
);

  // Only table entries that exist can be mapped
  localparam int ACTIVE = (NUM_MAPPED < TABLE_ENTRIES) ? NUM_MAPPED : TABLE_ENTRIES;
  localparam int IDX_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;

  logic             in_acc;
  item_t            item;
  logic [IDX_W-1:0] idx;
  code_t            cur_code;
  cmp_rsp_t         rsp;
  logic             out_free;
  emit_t            emit;

  assign in_acc          = key_in.valid && key_in.ready;
  assign item.ev_type    = key_in.ev_type;
  assign item.key_code   = key_in.key_code;
  assign item.key_value  = key_in.key_value;

  // Sequencer: decode, table walk, held-mark scan, Fn flag and marks
  fnlr_seq #(
    .ACTIVE     (ACTIVE),
    .IDX_W      (IDX_W),
    .CODE_SPACE (CODE_SPACE)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_acc      (in_acc),
    .item        (item),
    .in_ready    (key_in.ready),
    .idx         (idx),
    .cur_code    (cur_code),
    .rsp         (rsp),
    .out_free    (out_free),
    .emit        (emit)
  );

  // Shared table lookup and compare, one entry per cycle unless key_out stalls the Fn scan
  fnlr_cmp #(
    .IDX_W (IDX_W)
  ) u_cmp (
    .idx  (idx),
    .code (cur_code),
    .rsp  (rsp)
  );

  // Output register parts the sequencer from the sink
  fnlr_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .emit     (emit),
    .out_free (out_free),
    .key_out  (key_out)
  );

endmodule

// File: design/fnlr_checker.sv
module fnlr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [9:0] out_code,
  input logic [1:0] out_value,
  input logic       out_last
);

  // A stalled request keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_code) && $stable(out_value)
      && $stable(out_last))
    else $error("key_out payload changed while stalled");

  // One event at a time: ready drops right after an accepted request
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("key_in accepted a request while busy");

  // Only the Fn release burst gives non-final results, all releases
  a_burst_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> out_value == 2'd0)
    else $error("non-final result is not a release");

  // Reset leaves no result pending and the input open
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("result pending or input closed after reset");

endmodule

bind fn_layer_key_remapper_top fnlr_checker u_fnlr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (key_in.valid),
  .in_ready  (key_in.ready),
  .out_valid (key_out.valid),
  .out_ready (key_out.ready),
  .out_code  (key_out.out_code),
  .out_value (key_out.out_value),
  .out_last  (key_out.last)
);
